// ===== src/rtsu_pkg.sv =====
// ----------------------------------------------------------------------------
// rtsu_pkg
// Shared constants and types for the shortest-route table.
// ----------------------------------------------------------------------------
package rtsu_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] FUNC_INSTALL = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] via;
        logic [7:0] hops;
    } entry_t;

endpackage

// ===== src/route_table_shortest_update.sv =====
// A new request is accepted only in the idle state, after the previous result has
// been loaded into the output register. The entry RAM has a single read port, so
// the key search sweeps it one entry per cycle.
// A finished result waits in an output register while the next request enters.
// Reset clears all valid bits at once; the table is empty right after reset.
// ----------------------------------------------------------------------------
// route_table_shortest_update
// Route table keyed by destination id: install keeps the shorter route,
// lookup returns the next hop, clear empties the table.
// ----------------------------------------------------------------------------
module route_table_shortest_update (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] dest_id,
    input  logic [7:0] via_hop,
    input  logic [7:0] hop_count,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       hit,
    output logic [7:0] next_hop_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [rtsu_pkg::CNT_W-1:0] CNT_END =
        rtsu_pkg::CNT_W'(rtsu_pkg::TABLE_ENTRIES);
    localparam logic [rtsu_pkg::IDX_W-1:0] IDX_LAST =
        rtsu_pkg::IDX_W'(rtsu_pkg::TABLE_ENTRIES - 1);

    rtsu_pkg::entry_t entry_mem [rtsu_pkg::TABLE_ENTRIES];
    rtsu_pkg::entry_t rd_data_reg;
    rtsu_pkg::entry_t wr_data;

    logic [1:0] state_reg, state_next;
    logic [1:0] func_reg;
    logic [7:0] dest_reg, via_reg, hops_reg;

    logic [rtsu_pkg::CNT_W-1:0] addr_reg, addr_next;
    logic                       pend_reg, pend_next;
    logic [rtsu_pkg::IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic                       found_reg, found_next;
    logic [rtsu_pkg::IDX_W-1:0] slot_reg, slot_next;
    logic [7:0]                 old_via_reg, old_via_next;
    logic [7:0]                 old_hops_reg, old_hops_next;
    logic                       free_found_reg, free_found_next;
    logic [rtsu_pkg::IDX_W-1:0] free_idx_reg, free_idx_next;

    logic [rtsu_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic       out_valid_reg, out_valid_next;
    logic       hit_reg, hit_next;
    logic [7:0] nh_reg, nh_next;

    logic                       accept;
    logic                       rd_en;
    logic                       match;
    logic                       free_slot;
    logic                       out_load;
    logic                       better;
    logic                       wr_en;
    logic [rtsu_pkg::IDX_W-1:0] wr_idx;

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign next_hop_out = nh_reg;

    assign rd_en     = (state_reg == ST_SCAN) && (addr_reg < CNT_END);
    assign match     = pend_reg && valid_reg[pend_idx_reg] && (rd_data_reg.dest == dest_reg);
    assign free_slot = pend_reg && !valid_reg[pend_idx_reg];
    assign out_load  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign better    = (hops_reg < old_hops_reg);
    assign wr_en     = out_load && (func_reg == rtsu_pkg::FUNC_INSTALL) &&
                       (!found_reg || better);
    assign wr_idx    = found_reg ? slot_reg : (free_found_reg ? free_idx_reg : '0);
    assign wr_data   = '{dest: dest_reg, via: via_reg, hops: hops_reg};

    // entry RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[addr_reg[rtsu_pkg::IDX_W-1:0]];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        old_via_next    = old_via_reg;
        old_hops_next   = old_hops_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        nh_next         = nh_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next       = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    addr_next     = addr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg[rtsu_pkg::IDX_W-1:0];
                end
                // keep the lowest-numbered match and the lowest free slot
                if (match && !found_reg)
                begin
                    found_next    = 1'b1;
                    slot_next     = pend_idx_reg;
                    old_via_next  = rd_data_reg.via;
                    old_hops_next = rd_data_reg.hops;
                end
                if (free_slot && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pend_idx_reg;
                end
                if (pend_reg && (pend_idx_reg == IDX_LAST))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = found_reg;
                    nh_next        = '0;
                    unique case (func_reg)
                        rtsu_pkg::FUNC_INSTALL:
                        begin
                            if (found_reg)
                            begin
                                nh_next = better ? via_reg : old_via_reg;
                            end
                            else
                            begin
                                valid_next[wr_idx] = 1'b1;
                            end
                        end
                        rtsu_pkg::FUNC_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                            if (found_reg)
                            begin
                                nh_next = old_via_reg;
                            end
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_reg       <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold the request and search results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            dest_reg <= dest_id;
            via_reg  <= via_hop;
            hops_reg <= hop_count;
        end
        addr_reg       <= addr_next;
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        old_via_reg    <= old_via_next;
        old_hops_reg   <= old_hops_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_reg        <= hit_next;
        nh_reg         <= nh_next;
    end

endmodule
